>>> sv/shabsh_pkg.sv
package shabsh_pkg;

    // one input transaction as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } t_item;

    // write side of the queue
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_wr;

    // read side of the queue
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_rd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_COMP,
        ST_FINAL
    } t_state;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [6:0] FILL_LAST  = 7'd63;
    localparam logic [6:0] FILL_LEN   = 7'd56;
    localparam logic [6:0] FILL_FULL  = 7'd64;
    localparam logic [6:0] CNT_LOAD   = 7'd0;
    localparam logic [6:0] CNT_W_LO   = 7'd1;
    localparam logic [6:0] CNT_W_HI   = 7'd64;
    localparam logic [6:0] CNT_R_LO   = 7'd2;
    localparam logic [6:0] CNT_R_HI   = 7'd65;
    localparam logic [6:0] CNT_DONE   = 7'd66;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_ror(input logic [31:0] x, input int n);
        f_ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        f_bsig0 = f_ror(x, 2) ^ f_ror(x, 13) ^ f_ror(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        f_bsig1 = f_ror(x, 6) ^ f_ror(x, 11) ^ f_ror(x, 25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        f_ssig0 = f_ror(x, 7) ^ f_ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        f_ssig1 = f_ror(x, 17) ^ f_ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
        f_ch = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        f_maj = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> sv/shabsh_front.sv
module shabsh_front (
    input  logic                i_valid,
    input  shabsh_pkg::t_item   i_item,
    input  logic                i_full,
    output logic                o_stall,
    output shabsh_pkg::t_q_wr   o_wr
);

    // idle transactions (no byte, not last) are taken and dropped here
    logic w_useful;

    assign w_useful    = i_item.has_data | i_item.last;
    assign o_stall     = i_full;
    assign o_wr.valid  = i_valid & ~i_full & w_useful;
    assign o_wr.item   = i_item;

endmodule

>>> sv/shabsh_queue.sv
module shabsh_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shabsh_pkg::t_q_wr   i_wr,
    output logic                o_full,
    input  logic                i_pop,
    output shabsh_pkg::t_q_rd   o_rd
);

    shabsh_pkg::t_item              r_mem [shabsh_pkg::Q_DEPTH];
    logic [shabsh_pkg::Q_AW-1:0]    r_wp, n_wp;
    logic [shabsh_pkg::Q_AW-1:0]    r_rp, n_rp;
    logic [shabsh_pkg::Q_CW-1:0]    r_count, n_count;
    logic                           w_push, w_pop;

    localparam logic [shabsh_pkg::Q_CW-1:0] CNT_FULL = shabsh_pkg::Q_CW'(shabsh_pkg::Q_DEPTH);
    localparam logic [shabsh_pkg::Q_AW-1:0] PTR_LAST =
        shabsh_pkg::Q_AW'(shabsh_pkg::Q_DEPTH - 1);

    assign o_full     = (r_count == CNT_FULL);
    assign w_push     = i_wr.valid & ~o_full;
    assign w_pop      = i_pop & (r_count != '0);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.item  = r_mem[r_rp];

    always_comb begin
        n_wp    = w_push ? ((r_wp == PTR_LAST) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp    = w_pop  ? ((r_rp == PTR_LAST) ? '0 : r_rp + 1'b1) : r_rp;
        n_count = r_count + shabsh_pkg::Q_CW'(w_push) - shabsh_pkg::Q_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr.item;
        end
    end

endmodule

>>> sv/shabsh_back.sv
module shabsh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shabsh_pkg::t_q_rd   i_rd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_digest_0,
    output logic [63:0]         o_digest_1,
    output logic [63:0]         o_digest_2,
    output logic [63:0]         o_digest_3
);

    shabsh_pkg::t_state r_state, n_state;
    shabsh_pkg::t_state r_ret, n_ret;

    logic [6:0]  r_fill, n_fill;
    logic [63:0] r_msg, n_msg;
    logic [63:0] r_len, n_len;
    logic [6:0]  r_cnt, n_cnt;

    logic [31:0] r_chain [8];
    logic [31:0] r_rr    [8];
    logic [31:0] r_sched [16];
    logic [31:0] r_w;
    logic [31:0] r_rdata;
    logic [31:0] r_mem   [16];

    logic        r_out_valid;
    logic [63:0] r_digest [4];

    logic        w_we;
    logic [7:0]  w_wbyte;
    logic        w_load_out;
    logic        w_restart;
    logic        w_out_free;
    logic        w_comp;
    logic [5:0]  w_widx;
    logic [5:0]  w_ridx;
    logic [31:0] w_wnext;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_out_free = ~r_out_valid | ~i_stall;
    assign w_comp     = (r_state == shabsh_pkg::ST_COMP);

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            shabsh_pkg::ST_IDLE: begin
                if (i_rd.valid) begin
                    if (i_rd.item.has_data && r_fill == shabsh_pkg::FILL_LAST) begin
                        n_state = shabsh_pkg::ST_COMP;
                        n_ret   = i_rd.item.last ? shabsh_pkg::ST_PAD80 : shabsh_pkg::ST_IDLE;
                    end else if (i_rd.item.last) begin
                        n_state = shabsh_pkg::ST_PAD80;
                    end
                end
            end
            shabsh_pkg::ST_PAD80: begin
                n_state = shabsh_pkg::ST_PADZ;
            end
            shabsh_pkg::ST_PADZ: begin
                if (r_fill == shabsh_pkg::FILL_LEN) begin
                    n_state = shabsh_pkg::ST_LEN;
                end else if (r_fill == shabsh_pkg::FILL_FULL) begin
                    n_state = shabsh_pkg::ST_COMP;
                    n_ret   = shabsh_pkg::ST_PADZ;
                end
            end
            shabsh_pkg::ST_LEN: begin
                if (r_fill == shabsh_pkg::FILL_LAST) begin
                    n_state = shabsh_pkg::ST_COMP;
                    n_ret   = shabsh_pkg::ST_FINAL;
                end
            end
            shabsh_pkg::ST_COMP: begin
                if (r_cnt == shabsh_pkg::CNT_DONE) begin
                    n_state = r_ret;
                end
            end
            shabsh_pkg::ST_FINAL: begin
                if (w_out_free) begin
                    n_state = shabsh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shabsh_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and buffer control
    always_comb begin
        w_we       = 1'b0;
        w_wbyte    = '0;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        w_restart  = 1'b0;
        n_fill     = r_fill;
        n_msg      = r_msg;
        n_len      = r_len;
        n_cnt      = w_comp ? r_cnt + 7'd1 : shabsh_pkg::CNT_LOAD;
        case (r_state)
            shabsh_pkg::ST_IDLE: begin
                o_pop = i_rd.valid;
                if (i_rd.valid && i_rd.item.has_data) begin
                    w_we    = 1'b1;
                    w_wbyte = i_rd.item.data;
                    n_msg   = r_msg + 64'd1;
                    n_fill  = (r_fill == shabsh_pkg::FILL_LAST) ? '0 : r_fill + 7'd1;
                end
            end
            shabsh_pkg::ST_PAD80: begin
                w_we    = 1'b1;
                w_wbyte = shabsh_pkg::PAD_BYTE;
                n_fill  = r_fill + 7'd1;
                n_len   = {r_msg[60:0], 3'b000};
            end
            shabsh_pkg::ST_PADZ: begin
                if (r_fill == shabsh_pkg::FILL_FULL) begin
                    n_fill = '0;
                end else if (r_fill != shabsh_pkg::FILL_LEN) begin
                    w_we   = 1'b1;
                    n_fill = r_fill + 7'd1;
                end
            end
            shabsh_pkg::ST_LEN: begin
                w_we    = 1'b1;
                w_wbyte = r_len[63:56];
                n_len   = {r_len[55:0], 8'h00};
                n_fill  = (r_fill == shabsh_pkg::FILL_LAST) ? '0 : r_fill + 7'd1;
            end
            shabsh_pkg::ST_COMP: begin
            end
            shabsh_pkg::ST_FINAL: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_restart  = 1'b1;
                    n_fill     = '0;
                    n_msg      = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // schedule word and round logic
    assign w_widx = r_cnt[5:0] - 6'd1;
    assign w_ridx = r_cnt[5:0] - 6'd2;

    always_comb begin
        if (w_widx[5:4] == 2'b00) begin
            w_wnext = r_rdata;
        end else begin
            w_wnext = shabsh_pkg::f_ssig1(r_sched[14]) + r_sched[9]
                    + shabsh_pkg::f_ssig0(r_sched[1]) + r_sched[0];
        end
        w_t1 = r_rr[7] + shabsh_pkg::f_bsig1(r_rr[4])
             + shabsh_pkg::f_ch(r_rr[4], r_rr[5], r_rr[6])
             + shabsh_pkg::K_ROUND[w_ridx] + r_w;
        w_t2 = shabsh_pkg::f_bsig0(r_rr[0]) + shabsh_pkg::f_maj(r_rr[0], r_rr[1], r_rr[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shabsh_pkg::ST_IDLE;
            r_ret       <= shabsh_pkg::ST_IDLE;
            r_fill      <= '0;
            r_msg       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_chain     <= shabsh_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_restart) begin
                r_chain <= shabsh_pkg::H_INIT;
            end else if (w_comp && r_cnt == shabsh_pkg::CNT_DONE) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + r_rr[j];
                end
            end
        end
    end

    // block buffer, big-endian bytes within each word
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= w_wbyte;
        end
        r_rdata <= r_mem[r_cnt[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_comp && r_cnt == shabsh_pkg::CNT_LOAD) begin
            r_rr <= r_chain;
        end
        if (w_comp && r_cnt >= shabsh_pkg::CNT_W_LO && r_cnt <= shabsh_pkg::CNT_W_HI) begin
            r_w <= w_wnext;
            for (int j = 0; j < 15; j++) begin
                r_sched[j] <= r_sched[j + 1];
            end
            r_sched[15] <= w_wnext;
        end
        if (w_comp && r_cnt >= shabsh_pkg::CNT_R_LO && r_cnt <= shabsh_pkg::CNT_R_HI) begin
            // e takes d + t1, a takes t1 + t2, the rest shift down
            for (int j = 1; j < 8; j++) begin
                if (j != 4) begin
                    r_rr[j] <= r_rr[j - 1];
                end
            end
            r_rr[4] <= r_rr[3] + w_t1;
            r_rr[0] <= w_t1 + w_t2;
        end
        if (w_load_out) begin
            for (int j = 0; j < 4; j++) begin
                r_digest[j] <= {r_chain[2 * j], r_chain[2 * j + 1]};
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_digest_0 = r_digest[0];
    assign o_digest_1 = r_digest[1];
    assign o_digest_2 = r_digest[2];
    assign o_digest_3 = r_digest[3];

endmodule

>>> sv/sha256_byte_stream_hasher.sv
// sha-256 hasher fed one message byte per input transaction
// input channel: i_valid / o_stall with i_data_byte, i_has_data, i_last;
//   a transaction with i_has_data low and i_last low is taken and dropped,
//   i_has_data low with i_last high closes the message (empty message allowed)
// output channel: o_valid / i_stall with o_digest_0..3, one transaction per
//   message, digest bytes in big-endian order, o_digest_0 carries bytes 0..7
// the front takes transactions into a two-entry queue; the back writes one byte
//   per cycle into the block buffer and runs the compression one round a cycle
// throughput: one byte per cycle until a block fills, then the input waits for the
//   64-round compression (one schedule word read from the buffer port per cycle)
// closing a message: the back writes 0x80, then the zero pad bytes, then the eight
//   length bytes, plus one or two compressions; the digest then loads into the output
//   register once that register is free, and the hash values restart
// reset (synchronous, i_rst_n low) empties the queue, drops a pending digest,
//   clears the byte counts and loads the initial hash values
// when the receiver stalls the digest holds in its output register; the back
//   waits with the next message's start until that register is free, and the
//   queue fills and raises o_stall
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_data,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_0,
    output logic [63:0] o_digest_1,
    output logic [63:0] o_digest_2,
    output logic [63:0] o_digest_3
);

    shabsh_pkg::t_item w_item;
    shabsh_pkg::t_q_wr w_wr;
    shabsh_pkg::t_q_rd w_rd;
    logic              w_full;
    logic              w_pop;

    // pack the input fields into one transaction record
    assign w_item.data     = i_data_byte;
    assign w_item.has_data = i_has_data;
    assign w_item.last     = i_last;

    // front: takes transactions and filters out idle ones
    shabsh_front u_front (
        .i_valid (i_valid),
        .i_item  (w_item),
        .i_full  (w_full),
        .o_stall (o_stall),
        .o_wr    (w_wr)
    );

    // short queue so front and back stall on their own
    shabsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rd    (w_rd)
    );

    // back: block buffer, padding sequencer, compression and digest register
    shabsh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (w_rd),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_digest_0 (o_digest_0),
        .o_digest_1 (o_digest_1),
        .o_digest_2 (o_digest_2),
        .o_digest_3 (o_digest_3)
    );

endmodule

>>> sim/sha256_byte_stream_hasher_tb.sv
module sha256_byte_stream_hasher_tb;

    // digest as it leaves the block: four big-endian 64-bit words
    typedef struct packed {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
    } sha_digest_t;

    // one row of the directed table; chk marks a digest typed in by hand
    typedef struct packed {
        logic [7:0]   data;
        logic         has_data;
        logic         last;
        logic         chk;
        sha_digest_t  digest;
    } directed_row_t;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         LEN_OFFSET = 56;
    localparam int         BLOCK_SIZE = 64;

    // well-known digests
    localparam sha_digest_t DIGEST_EMPTY =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam sha_digest_t DIGEST_ABC =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // message lengths right at the padding boundaries
    localparam int PAD_EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam int N_DIRECTED   = 18;
    localparam int RANDOM_ITEMS = 1750;
    localparam int LONG_HOLD    = 1500;
    localparam int DRAIN_CYCLES = 250;

    // directed table: extremes of the byte, idle transactions, empty messages,
    // a close without a data byte, and the classic three-byte message
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},   // empty message right after reset
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, 1'b0, '0},             // idle transaction mid message
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},             // single zero byte
        '{8'hff, 1'b1, 1'b1, 1'b0, '0},             // single all-ones byte
        '{8'h5a, 1'b0, 1'b0, 1'b0, '0},             // idle between messages
        '{8'ha5, 1'b1, 1'b0, 1'b0, '0},
        '{8'h3c, 1'b1, 1'b0, 1'b0, '0},
        '{8'hc3, 1'b0, 1'b1, 1'b0, '0},             // close without a data byte
        '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},   // empty again, byte ignored
        '{8'h80, 1'b1, 1'b0, 1'b0, '0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b0, 1'b0, '0},
        '{8'h64, 1'b0, 1'b1, 1'b1, DIGEST_ABC}      // same text, closed by an end item
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_data;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_digest_0;
    logic [63:0] o_digest_1;
    logic [63:0] o_digest_2;
    logic [63:0] o_digest_3;

    // hash state of the message being fed
    logic [31:0] hash_chain [8];
    logic [7:0]  blk_bytes [BLOCK_SIZE];
    int unsigned blk_fill;
    logic [63:0] msg_len;

    sha_digest_t pending_digests [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_req;
    int mismatch_count;
    int digests_checked;
    int bytes_sent;
    int msgs_closed;
    int random_items;

    sha256_byte_stream_hasher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_has_data  (i_has_data),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_digest_0  (o_digest_0),
        .o_digest_1  (o_digest_1),
        .o_digest_2  (o_digest_2),
        .o_digest_3  (o_digest_3)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64-round compression of the buffered block into the chaining words
    function automatic void compress_buffered_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            w[t] = w[t-16]
                 + (rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7]
                 + (rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
        for (t = 0; t < 64; t++) begin
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                   + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + w[t];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endfunction

    function automatic void restart_message();
        for (int j = 0; j < 8; j++) hash_chain[j] = IV_WORDS[j];
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    // feeds one accepted transaction to the hash state; returns 1 with the
    // digest when the transaction closes the message
    function automatic bit absorb_item(input logic [7:0] d, input logic has, input logic last,
                                       output sha_digest_t dg);
        logic [63:0] bitlen;
        int unsigned j;
        dg = '0;
        if (has) begin
            blk_bytes[blk_fill] = d;
            blk_fill++;
            msg_len++;
            if (blk_fill == BLOCK_SIZE) begin
                compress_buffered_block();
                blk_fill = 0;
            end
        end
        if (!last) return 1'b0;
        bitlen = msg_len << 3;
        blk_bytes[blk_fill] = PAD_MARK;
        blk_fill++;
        // no room left for the length: pad out and run an extra block
        if (blk_fill > LEN_OFFSET) begin
            for (j = blk_fill; j < BLOCK_SIZE; j++) blk_bytes[j] = 8'h00;
            compress_buffered_block();
            blk_fill = 0;
        end
        for (j = blk_fill; j < LEN_OFFSET; j++) blk_bytes[j] = 8'h00;
        for (j = 0; j < 8; j++) blk_bytes[BLOCK_SIZE - 1 - j] = bitlen[8*j +: 8];
        compress_buffered_block();
        dg = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3],
              hash_chain[4], hash_chain[5], hash_chain[6], hash_chain[7]};
        restart_message();
        return 1'b1;
    endfunction

    // mostly short messages, a good share at the padding boundaries,
    // some empty, a few spanning several blocks
    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(99);
        if (r < 15) return PAD_EDGE_LENS[$urandom_range(9)];
        if (r < 22) return 0;
        if (r < 85) return $urandom_range(60, 1);
        if (r < 97) return $urandom_range(200, 61);
        return $urandom_range(400, 201);
    endfunction

    // offers one transaction at a falling edge, holds it until taken, then
    // returns at the next falling edge with valid still high
    task automatic offer_item(input logic [7:0] d, input logic has, input logic last,
                              input logic chk, input sha_digest_t typed);
        sha_digest_t dg;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_has_data  <= has;
        i_last      <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (absorb_item(d, has, last, dg)) begin
            pending_digests.push_back(chk ? typed : dg);
            msgs_closed++;
        end
        if (has) bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic compare_word(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver side: random stall, or one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                for (n = 0; n < LONG_HOLD; n++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // digest checker: every transaction taken must match the oldest expectation
    always @(posedge i_clk) begin : check_digest
        sha_digest_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digests.size() == 0) begin
                $error("digest with no message outstanding: %h %h %h %h",
                       o_digest_0, o_digest_1, o_digest_2, o_digest_3);
                mismatch_count++;
            end else begin
                want = pending_digests.pop_front();
                compare_word("digest_0", want.w0, o_digest_0);
                compare_word("digest_1", want.w1, o_digest_1);
                compare_word("digest_2", want.w2, o_digest_2);
                compare_word("digest_3", want.w3, o_digest_3);
                digests_checked++;
            end
        end
    end

    // hang guard
    initial begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int phase;
        int len;
        int k;
        bit sep_end;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = 8'h00;
        i_has_data      = 1'b0;
        i_last          = 1'b0;
        long_hold_req   = 1'b0;
        mismatch_count  = 0;
        digests_checked = 0;
        bytes_sent      = 0;
        msgs_closed     = 0;
        random_items    = 0;
        // sender idles 30 percent, receiver 71 percent to begin with
        send_idle_pct   = 30;
        recv_idle_pct   = 71;
        phase           = 0;
        restart_message();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        for (k = 0; k < N_DIRECTED; k++) begin
            offer_item(DIRECTED_ROWS[k].data, DIRECTED_ROWS[k].has_data,
                       DIRECTED_ROWS[k].last, DIRECTED_ROWS[k].chk, DIRECTED_ROWS[k].digest);
        end

        // random messages, one message per loop pass
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0 && random_items >= RANDOM_ITEMS / 3) begin
                // sender pauses until every digest is out, then roles swap
                while (pending_digests.size() != 0) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                end
                phase         = 1;
                send_idle_pct = 71;
                recv_idle_pct = 30;
            end else if (phase == 1 && random_items >= 2 * RANDOM_ITEMS / 3) begin
                // full rate both ways, opened by a long receiver hold-off so the
                // output register and the input queue back up
                phase         = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_req = 1'b1;
            end
            len     = pick_msg_len();
            sep_end = ($urandom_range(99) < 20);
            for (k = 0; k < len; k++) begin
                // occasional idle transaction with junk in the byte
                if ($urandom_range(99) < 4)
                    offer_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
                offer_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && !sep_end,
                           1'b0, '0);
                random_items++;
            end
            if (len == 0 || sep_end) begin
                offer_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
                random_items++;
            end
        end
        i_valid <= 1'b0;

        // drain: every digest out, then a margin for anything unexpected
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d message bytes in %0d messages, %0d digests compared",
                 bytes_sent, msgs_closed, digests_checked);
        $display("stall mixes 30/71, 71/30 and none, with one long output hold-off");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
